// File: src/e2q_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the Euler-to-quaternion core.
package e2q_pkg;

    localparam int ANGLE_BITS_DEF          = 16;
    localparam int COMPONENT_FRAC_BITS_DEF = 15;
    localparam int FIELD_BITS              = 16;
    localparam int CORDIC_STEPS            = 30;
    localparam int CORDIC_STEP_BITS        = 5;
    // Iterations done per pipeline stage; 30 steps over 10 stages.
    localparam int STEPS_PER_STAGE         = 3;
    localparam int CORDIC_STAGES           = CORDIC_STEPS / STEPS_PER_STAGE;
    // Datapath width: Q2.30 with headroom.
    localparam int XY_BITS                 = 34;
    localparam int Z_BITS                  = 34;
    localparam logic signed [XY_BITS-1:0] CORDIC_GAIN = 34'sd652032874;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [Z_BITS-1:0] atan_entry(input logic [CORDIC_STEP_BITS-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return $signed({2'b00, v});
    endfunction

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] roll_angle;
        logic signed [FIELD_BITS-1:0] pitch_angle;
        logic signed [FIELD_BITS-1:0] yaw_angle;
    } t_angles;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] quat_x;
        logic signed [FIELD_BITS-1:0] quat_y;
        logic signed [FIELD_BITS-1:0] quat_z;
        logic signed [FIELD_BITS-1:0] quat_w;
    } t_quat;

endpackage

// File: src/e2q_if.sv
// Valid/ready channel interfaces for angle and quaternion beats.
interface e2q_angle_if import e2q_pkg::*; ();
    logic    valid;
    logic    ready;
    t_angles data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface e2q_quat_if import e2q_pkg::*; ();
    logic  valid;
    logic  ready;
    t_quat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/e2q_cordic.sv
// Pipelined CORDIC giving sine and cosine of half a binary angle, several steps per stage.
module e2q_cordic import e2q_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = COMPONENT_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [FIELD_BITS-1:0]  i_angle,
    output logic signed [FRAC_BITS+1:0] o_sin,
    output logic signed [FRAC_BITS+1:0] o_cos
);
    localparam int SH = 30 - FRAC_BITS;
    localparam int CB = FRAC_BITS + 2;

    logic signed [XY_BITS-1:0] r_x [CORDIC_STAGES+1];
    logic signed [XY_BITS-1:0] r_y [CORDIC_STAGES+1];
    logic signed [Z_BITS-1:0]  r_z [CORDIC_STAGES+1];
    logic [31:0]               angle_ext;

    // The field is zero-extended so that any angle width up to 32 bits can be selected.
    assign angle_ext = 32'(i_angle);

    // Load: sign-extend the angle and scale so its half lands in 2^-32 turn units.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= Z_BITS'($signed(angle_ext[ANGLE_BITS-1:0])) <<< (31 - ANGLE_BITS);
        end
    end

    // Rotation stages.
    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
        logic signed [XY_BITS-1:0] x_c, y_c;
        logic signed [Z_BITS-1:0]  z_c;
        always_comb begin
            logic signed [XY_BITS-1:0] dx, dy;
            x_c = r_x[s];
            y_c = r_y[s];
            z_c = r_z[s];
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                dx = y_c >>> (s*STEPS_PER_STAGE + k);
                dy = x_c >>> (s*STEPS_PER_STAGE + k);
                if (!z_c[Z_BITS-1]) begin
                    x_c = x_c - dx;
                    y_c = y_c + dy;
                    z_c = z_c - atan_entry(CORDIC_STEP_BITS'(s*STEPS_PER_STAGE + k));
                end else begin
                    x_c = x_c + dx;
                    y_c = y_c - dy;
                    z_c = z_c + atan_entry(CORDIC_STEP_BITS'(s*STEPS_PER_STAGE + k));
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s+1] <= x_c;
                r_y[s+1] <= y_c;
                r_z[s+1] <= z_c;
            end
        end
    end

    // Round half up to FRAC_BITS and clamp to plus or minus one.
    function automatic logic signed [CB-1:0] rnd(input logic signed [XY_BITS-1:0] v);
        logic signed [XY_BITS-1:0] t;
        logic signed [XY_BITS-1:0] one;
        t   = (v + (XY_BITS'(1) <<< (SH-1))) >>> SH;
        one = XY_BITS'(1) <<< FRAC_BITS;
        if (t > one)       t = one;
        else if (t < -one) t = -one;
        return t[CB-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= rnd(r_x[CORDIC_STAGES]);
            o_sin <= rnd(r_y[CORDIC_STAGES]);
        end
    end
endmodule

// File: src/e2q_combine.sv
// Pair products, component products and final rounding with saturation.
module e2q_combine import e2q_pkg::*; #(
    parameter int FRAC_BITS = COMPONENT_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [FRAC_BITS+1:0] i_sr, i_cr, i_sp, i_cp, i_sy, i_cy,
    output t_quat                      o_quat
);
    localparam int CB = FRAC_BITS + 2;
    localparam int PB = 2*CB;
    localparam int SB = PB + 2;

    logic signed [CB-1:0] r_sy, r_cy;
    logic signed [PB-1:0] r_crsp, r_srcp, r_crcp, r_srsp;
    logic signed [CB-1:0] r_p_crsp, r_p_srcp, r_p_crcp, r_p_srsp;
    logic signed [CB-1:0] r_sy2, r_cy2;
    logic signed [PB-1:0] r_m [8];

    function automatic logic signed [CB-1:0] rp(input logic signed [PB-1:0] v);
        logic signed [PB-1:0] t;
        t = (v + (PB'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
        return t[CB-1:0];
    endfunction

    function automatic logic signed [FIELD_BITS-1:0] fin(input logic signed [SB-1:0] v);
        logic signed [SB-1:0] t, lim;
        t   = (v + (SB'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
        lim = (SB'(1) <<< FRAC_BITS) - SB'(1);
        if (t > lim)       t = lim;
        else if (t < -lim) t = -lim;
        return t[FIELD_BITS-1:0];
    endfunction

    // Stage A: roll-pitch pair products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_crsp <= i_cr * i_sp;
            r_srcp <= i_sr * i_cp;
            r_crcp <= i_cr * i_cp;
            r_srsp <= i_sr * i_sp;
            r_sy   <= i_sy;
            r_cy   <= i_cy;
        end
    end

    // Stage B: round the pair products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_crsp <= rp(r_crsp);
            r_p_srcp <= rp(r_srcp);
            r_p_crcp <= rp(r_crcp);
            r_p_srsp <= rp(r_srsp);
            r_sy2    <= r_sy;
            r_cy2    <= r_cy;
        end
    end

    // Stage C: products with the yaw terms.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= r_p_crsp * r_sy2;
            r_m[1] <= r_p_srcp * r_cy2;
            r_m[2] <= r_p_crsp * r_cy2;
            r_m[3] <= r_p_srcp * r_sy2;
            r_m[4] <= r_p_crcp * r_sy2;
            r_m[5] <= r_p_srsp * r_cy2;
            r_m[6] <= r_p_crcp * r_cy2;
            r_m[7] <= r_p_srsp * r_sy2;
        end
    end

    // Stage D: sum with the sign pattern, round and saturate.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quat.quat_x <= fin(SB'(r_m[0]) - SB'(r_m[1]));
            o_quat.quat_y <= fin(-SB'(r_m[2]) - SB'(r_m[3]));
            o_quat.quat_z <= fin(SB'(r_m[4]) - SB'(r_m[5]));
            o_quat.quat_w <= fin(SB'(r_m[6]) + SB'(r_m[7]));
        end
    end
endmodule

// File: src/euler_to_quaternion_core.sv
// Top level: Euler angles to quaternion, pipelined with a skid-free stall scheme.
// One angle beat is accepted every clock cycle while the output is not stalled,
// and one quaternion beat leaves per item. The pipeline is one load stage, ten
// CORDIC stages of three rotation steps each, one sine/cosine rounding stage and
// four product/rounding stages. The whole pipeline advances when the output
// register is empty or taken, so a stall on the output holds every stage in place.
module euler_to_quaternion_core import e2q_pkg::*; #(
    parameter int ANGLE_BITS          = ANGLE_BITS_DEF,
    parameter int COMPONENT_FRAC_BITS = COMPONENT_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    e2q_angle_if.sink  s_in,
    e2q_quat_if.source m_out
);
    localparam int FB    = COMPONENT_FRAC_BITS;
    localparam int DEPTH = CORDIC_STAGES + 6;

    logic [DEPTH-1:0] r_vld;
    logic             adv;
    logic signed [FB+1:0] sr, cr, sp, cp, sy, cy;

    // Advance when the last stage is empty or its beat is taken.
    assign adv         = !r_vld[DEPTH-1] || m_out.ready;
    assign s_in.ready  = adv;
    assign m_out.valid = r_vld[DEPTH-1];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[DEPTH-2:0], s_in.valid};
        end
    end

    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FB)) u_roll (
        .i_clk(i_clk), .i_en(adv), .i_angle(s_in.data.roll_angle), .o_sin(sr), .o_cos(cr));
    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FB)) u_pitch (
        .i_clk(i_clk), .i_en(adv), .i_angle(s_in.data.pitch_angle), .o_sin(sp), .o_cos(cp));
    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FB)) u_yaw (
        .i_clk(i_clk), .i_en(adv), .i_angle(s_in.data.yaw_angle), .o_sin(sy), .o_cos(cy));

    e2q_combine #(.FRAC_BITS(FB)) u_combine (
        .i_clk(i_clk), .i_en(adv),
        .i_sr(sr), .i_cr(cr), .i_sp(sp), .i_cp(cp), .i_sy(sy), .i_cy(cy),
        .o_quat(m_out.data));
endmodule
